### hw/rtl/page_run_bitmap_allocator_macros.svh
// Assertion macros shared by the page run bitmap allocator RTL.
// Depends on nothing; the using module must provide clk_i and rst_ni.
`ifndef PAGE_RUN_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_RUN_BITMAP_ALLOCATOR_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define PRBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked on every rising edge outside reset.
`define PRBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/prba_pkg.sv
// Shared types and constants of the page run bitmap allocator.
// Depends on nothing; used by page_run_bitmap_allocator and the testbench.
package prba_pkg;

  // Command codes carried on the input tuser.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Field widths of the input and result words.
  localparam int unsigned CountW = 8;
  localparam int unsigned PageW  = 8;
  localparam int unsigned StatW  = 9;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_DONE
  } state_e;

endpackage

### hw/rtl/page_run_bitmap_allocator.sv
// Top level of the page run bitmap allocator: command handshake, scan and
// mark sequencer, page counters and result register.
// Depends on prba_pkg, prba_mark_ram and page_run_bitmap_allocator_macros.svh.
//
// The block keeps one used mark per page of a heap of PAGES pages in a single
// synchronous memory; page 0 is the heap header and is never handed out. An
// allocate word scans the marks first fit from page 1 at one page per cycle,
// then writes the marks of the found run one page per cycle. A free word
// clears page_count marks at one page per cycle; a zero-page word goes
// straight to the result. After reset the block sweeps the memory once to
// clear it, with s_axis_tready low. A result waits in an output register,
// so a new command is taken while the previous result is still unclaimed;
// the result of that command is loaded once the register is free. The
// result counters show the state after the command, each cut to nine bits.
`include "page_run_bitmap_allocator_macros.svh"

module page_run_bitmap_allocator
  import prba_pkg::*;
#(
  parameter int unsigned PAGES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Command words.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] page_count, [15:8] start_page
  input  logic                s_axis_tuser,   // [0] command
  // Result words.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] first_page, [16:8] pages_used,
                                              // [25:17] pages_free, [34:26] high_water_page
  output logic                m_axis_tuser    // [0] ok
);

  // Address width of the mark memory, width of the page pointer (it must hold
  // both PAGES and the end of a free run), and width of the counter math.
  localparam int unsigned AW = $clog2(PAGES);
  localparam int unsigned KW = (AW + 1 > 9) ? AW + 1 : 9;
  localparam int unsigned CW = $clog2(PAGES + 1);
  localparam int unsigned XW = KW + 1;

  state_e state_q, state_d;

  logic [KW-1:0]     ptr_q, ptr_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] need_q, need_d;
  logic [CountW-1:0] run_q, run_d;
  logic              pend_q, pend_d;

  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] free_q, free_d;
  logic [CW-1:0] touched_q, touched_d;

  logic             res_ok_q, res_ok_d;
  logic [PageW-1:0] res_first_q, res_first_d;

  logic                m_valid_q, m_valid_d;
  logic                m_user_q, m_user_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic          mem_we, mem_wdata, mem_re, rd_bit;
  logic [AW-1:0] mem_waddr, mem_raddr;

  logic              in_fire;
  logic              in_cmd;
  logic [CountW-1:0] in_count;
  logic [PageW-1:0]  in_from;

  logic              scan_hit, scan_end;
  logic [KW-1:0]     scan_pos;
  logic [KW-1:0]     hit_start;
  logic [CountW-1:0] run_inc;
  logic              out_free;

  logic [XW-1:0] used_sum, free_sum, count_x, used_x, free_x, touched_x, end_x, pages_x;
  logic [CW+StatW-1:0] used_ext, free_ext, touched_ext;

  assign in_cmd   = s_axis_tuser;
  assign in_count = s_axis_tdata[CountW-1:0];
  assign in_from  = s_axis_tdata[InDataW-1:CountW];
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;

  // The scan reads one page ahead: the bit in the read register belongs to
  // the page just below the pointer.
  assign scan_pos  = ptr_q - KW'(1);
  assign run_inc   = run_q + CountW'(1);
  assign scan_hit  = pend_q && !rd_bit && (run_inc == need_q);
  assign scan_end  = pend_q && !scan_hit && (scan_pos == KW'(PAGES - 1));
  assign hit_start = ptr_q - KW'(need_q);

  assign count_x   = XW'(in_count);
  assign used_x    = XW'(used_q);
  assign free_x    = XW'(free_q);
  assign touched_x = XW'(touched_q);
  assign end_x     = XW'(ptr_q);
  assign pages_x   = XW'(PAGES);
  assign used_sum  = used_x + XW'(need_q);
  assign free_sum  = free_x + count_x;

  prba_mark_ram #(
    .Depth (PAGES),
    .AddrW (AW)
  ) u_mark_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (rd_bit)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (ptr_q == KW'(PAGES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_count == '0) begin
            state_d = ST_DONE;
          end else if (in_cmd == CMD_FREE) begin
            state_d = ST_FREE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_d = ST_MARK;
        end else if (scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_MARK, ST_FREE: begin
        if (rem_q == CountW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, counters, memory controls and result register.
  always_comb begin
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    need_d      = need_q;
    run_d       = run_q;
    pend_d      = pend_q;
    used_d      = used_q;
    free_d      = free_q;
    touched_d   = touched_q;
    res_ok_d    = res_ok_q;
    res_first_d = res_first_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_user_d    = m_user_q;
    m_data_d    = m_data_q;
    mem_we      = 1'b0;
    mem_wdata   = 1'b0;
    mem_waddr   = ptr_q[AW-1:0];
    mem_re      = 1'b0;
    mem_raddr   = ptr_q[AW-1:0];

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + KW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_ok_d    = 1'b0;
          res_first_d = '0;
          if (in_count != '0) begin
            rem_d  = in_count;
            need_d = in_count;
            run_d  = '0;
            pend_d = 1'b0;
            if (in_cmd == CMD_FREE) begin
              // Freeing is unchecked and the counters saturate at their limits.
              ptr_d    = KW'(in_from);
              res_ok_d = 1'b1;
              free_d   = (free_sum > pages_x) ? CW'(PAGES) : free_sum[CW-1:0];
              used_d   = (used_x > count_x) ? CW'(used_x - count_x) : '0;
            end else begin
              ptr_d = KW'(1);
            end
          end
        end
      end
      ST_SCAN: begin
        mem_re = (ptr_q < KW'(PAGES));
        ptr_d  = ptr_q + KW'(1);
        pend_d = 1'b1;
        if (pend_q) begin
          run_d = rd_bit ? '0 : run_inc;
        end
        if (scan_hit) begin
          // The run ends at the page below the pointer, so the pointer is also
          // one past the run.
          ptr_d       = hit_start;
          rem_d       = need_q;
          res_ok_d    = 1'b1;
          res_first_d = hit_start[PageW-1:0];
          used_d      = (used_sum > pages_x) ? CW'(PAGES) : used_sum[CW-1:0];
          free_d      = (free_x > XW'(need_q)) ? CW'(free_x - XW'(need_q)) : '0;
          if (touched_x < end_x) begin
            touched_d = CW'(end_x);
          end
        end
      end
      ST_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b1;
        ptr_d     = ptr_q + KW'(1);
        rem_d     = rem_q - CountW'(1);
      end
      ST_FREE: begin
        // Pages past the end of the table are skipped.
        mem_we = (ptr_q < KW'(PAGES));
        ptr_d  = ptr_q + KW'(1);
        rem_d  = rem_q - CountW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = res_ok_q;
          m_data_d  = {5'b0, touched_ext[StatW-1:0], free_ext[StatW-1:0],
                       used_ext[StatW-1:0], res_first_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign used_ext    = (CW + StatW)'(used_q);
  assign free_ext    = (CW + StatW)'(free_q);
  assign touched_ext = (CW + StatW)'(touched_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ptr_q     <= '0;
      rem_q     <= '0;
      need_q    <= '0;
      run_q     <= '0;
      pend_q    <= 1'b0;
      used_q    <= CW'(1);
      free_q    <= CW'(PAGES - 1);
      touched_q <= CW'(1);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      rem_q     <= rem_d;
      need_q    <= need_d;
      run_q     <= run_d;
      pend_q    <= pend_d;
      used_q    <= used_d;
      free_q    <= free_d;
      touched_q <= touched_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_ok_q    <= res_ok_d;
    res_first_q <= res_first_d;
    m_user_q    <= m_user_d;
    m_data_q    <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

  // The scan only reads; no write may land while it runs.
  `PRBA_ASSERT_IMP(a_no_write_in_scan, mem_we, state_q != ST_SCAN, "mark write during scan")
  // Counters never leave the page range.
  `PRBA_ASSERT(a_used_range, XW'(used_q) <= pages_x, "used count out of range")
  `PRBA_ASSERT(a_free_range, XW'(free_q) <= pages_x, "free count out of range")
  `PRBA_ASSERT(a_high_range, XW'(touched_q) <= pages_x, "high-water mark out of range")
  // A result only appears when the sequencer finishes a command.
  `PRBA_ASSERT_IMP(a_result_from_done, $rose(m_axis_tvalid), $past(state_q == ST_DONE), "stray result")

endmodule

### hw/rtl/prba_mark_ram.sv
// Single-bit-wide page mark memory with one write and one registered read port.
// Depends on nothing; instantiated by page_run_bitmap_allocator.
module prba_mark_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic             wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic             rd_data_o
);

  logic mem_q [Depth];
  logic rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of page_run_bitmap_allocator: it drives command words,
// predicts every result word from its own page map and checks the result stream.
// Depends on prba_pkg and the page_run_bitmap_allocator RTL.

module tb;
  import prba_pkg::*;

  localparam int unsigned PAGES        = 256;
  localparam int unsigned RANDOM_WORDS = 1630;
  // No word may leave the block idle this long; the limit covers the clearing
  // sweep, the slowest allocate and the longest stalls.
  localparam int unsigned IDLE_LIMIT   = 4000;
  // Quiet time at the end, longer than the slowest command.
  localparam int unsigned TAIL_CYCLES  = 600;

  localparam int unsigned UsedLo = PageW;
  localparam int unsigned FreeLo = PageW + StatW;
  localparam int unsigned HighLo = PageW + 2 * StatW;
  localparam int unsigned PadLo  = PageW + 3 * StatW;

  typedef struct packed {
    logic             ok;
    logic [PageW-1:0] first_page;
    logic [StatW-1:0] pages_used;
    logic [StatW-1:0] pages_free;
    logic [StatW-1:0] high_water;
  } alloc_result_t;

  typedef struct {
    int unsigned first;
    int unsigned pages;
  } page_run_t;

  // Shadow of the allocator: its own page map and counters, plus the result
  // words that are owed by the block in the order the commands went in.
  class page_ledger;
    bit [PAGES-1:0] marks;
    int unsigned    used_pages;
    int unsigned    free_pages;
    int unsigned    high_water;
    alloc_result_t  owed[$];
    int unsigned    mismatches;

    function new();
      marks      = '0;
      used_pages = 1;
      free_pages = PAGES - 1;
      high_water = 1;
      mismatches = 0;
    endfunction

    // First fit from page 1; the header page is never part of a run.
    function bit first_fit(int unsigned need, output int unsigned start);
      int unsigned run;
      int unsigned pos;
      run   = 0;
      pos   = 1;
      start = 0;
      while (pos < PAGES) begin
        if (marks[pos]) run = 0;
        else run++;
        pos++;
        if (run == need) break;
      end
      if (run < need) return 1'b0;
      start = pos - need;
      return 1'b1;
    endfunction

    // Applies one accepted command to the shadow state and queues its result.
    function alloc_result_t take_command(logic cmd, logic [CountW-1:0] count,
                                         logic [PageW-1:0] from);
      alloc_result_t res;
      int unsigned   start;
      res = '0;
      if (count != 0) begin
        if (cmd == CMD_ALLOC) begin
          if (first_fit(32'(count), start)) begin
            for (int unsigned k = start; k < start + count && k < PAGES; k++)
              marks[k] = 1'b1;
            used_pages = (used_pages + count > PAGES) ? PAGES : used_pages + count;
            free_pages = (free_pages > count) ? free_pages - count : 0;
            if (high_water < start + count) high_water = start + count;
            res.ok         = 1'b1;
            res.first_page = PageW'(start);
          end
        end else begin
          // Pages past the end of the table are dropped, the counters still
          // move by the full count and saturate.
          for (int unsigned k = 32'(from); k < from + count; k++)
            if (k < PAGES) marks[k] = 1'b0;
          free_pages = (free_pages + count > PAGES) ? PAGES : free_pages + count;
          used_pages = (used_pages > count) ? used_pages - count : 0;
          res.ok     = 1'b1;
        end
      end
      res.pages_used = StatW'(used_pages);
      res.pages_free = StatW'(free_pages);
      res.high_water = StatW'(high_water);
      owed.push_back(res);
      return res;
    endfunction

    // Compares one accepted result word with the oldest owed result.
    function void match_result(logic ok, logic [OutDataW-1:0] data);
      alloc_result_t want;
      alloc_result_t got;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing owed: ok=%b data=%h", $time, ok, data);
        return;
      end
      want           = owed.pop_front();
      got.ok         = ok;
      got.first_page = data[PageW-1:0];
      got.pages_used = data[UsedLo +: StatW];
      got.pages_free = data[FreeLo +: StatW];
      got.high_water = data[HighLo +: StatW];
      if (got !== want || data[OutDataW-1:PadLo] !== '0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch: expected ok=%b first=%0d used=%0d free=%0d high=%0d",
                   $time, want.ok, want.first_page, want.pages_used, want.pages_free,
                   want.high_water);
          $display("  got ok=%b first=%0d used=%0d free=%0d high=%0d pad=%h",
                   got.ok, got.first_page, got.pages_used, got.pages_free,
                   got.high_water, data[OutDataW-1:PadLo]);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [7:0] page_count, [15:8] start_page
  logic                s_axis_tuser;   // [0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [7:0] first_page, [16:8] pages_used,
                                       // [25:17] pages_free, [34:26] high_water_page
  logic                m_axis_tuser;   // [0] ok

  page_ledger  ledger = new();
  page_run_t   live_runs[$];
  int unsigned tx_calm = 0;
  int unsigned rx_calm = 0;
  int unsigned rx_stall = 0;
  int unsigned idle_cycles = 0;

  page_run_bitmap_allocator #(
    .PAGES(PAGES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Idle lengths: mostly none or short, a few long, and now and then a calm
  // stretch in which that side never idles at all.
  function automatic int unsigned idle_length(ref int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 79) == 0) calm = $urandom_range(16, 64);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Result side: the ready line stalls at random. The word is taken at the edge
  // where valid and ready were both high, so values are read before they move.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      ledger.match_result(m_axis_tuser, m_axis_tdata);
    if (rx_stall != 0) rx_stall--;
    else rx_stall = idle_length(rx_calm);
    m_axis_tready <= (rx_stall == 0);
  end

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one command word and waits for it to be taken. Valid stays high
  // into the next word when no gap is drawn, so it is never lowered and raised
  // within the same step.
  task automatic send_word(input logic cmd, input int unsigned count,
                           input int unsigned from);
    int unsigned   gap;
    alloc_result_t res;
    page_run_t     run;
    gap = idle_length(tx_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {from[PageW-1:0], count[CountW-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    res = ledger.take_command(cmd, count[CountW-1:0], from[PageW-1:0]);
    if (cmd == CMD_ALLOC && res.ok) begin
      run.first = 32'(res.first_page);
      run.pages = count;
      live_runs.push_back(run);
    end
  endtask

  // Holds the sender back until every owed result has come out.
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (ledger.owed.size() != 0);
  endtask

  initial begin
    int unsigned r;
    int unsigned idx;
    int unsigned count;
    page_run_t   run;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= CMD_ALLOC;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: zero-page requests of both kinds, first fit around a
    // hole, the whole heap at once, a failing search on a full heap, frees
    // that run past the table or touch the header page, and saturation of
    // both counters.
    send_word(CMD_ALLOC, 0, 255);
    send_word(CMD_FREE, 0, 85);
    send_word(CMD_ALLOC, 1, 0);
    send_word(CMD_ALLOC, 1, 170);
    send_word(CMD_ALLOC, 255, 0);
    send_word(CMD_FREE, 1, 1);
    send_word(CMD_ALLOC, 2, 255);
    send_word(CMD_ALLOC, 1, 0);
    send_word(CMD_FREE, 255, 0);
    send_word(CMD_ALLOC, 255, 85);
    send_word(CMD_ALLOC, 1, 0);
    send_word(CMD_FREE, 20, 250);
    send_word(CMD_ALLOC, 6, 0);
    send_word(CMD_FREE, 255, 255);
    send_word(CMD_FREE, 128, 1);
    send_word(CMD_ALLOC, 128, 127);
    send_word(CMD_FREE, 85, 170);
    send_word(CMD_ALLOC, 128, 128);
    send_word(CMD_ALLOC, 127, 1);
    send_word(CMD_FREE, 255, 0);
    live_runs.delete();
    hold_until_drained();

    // Random part: mostly allocations and frees of runs that were really
    // handed out, with some noise of zero-page words and arbitrary frees.
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 400 == 399) hold_until_drained();
      if (i % 160 == 159) begin
        send_word(CMD_FREE, 255, 0);
        live_runs.delete();
      end
      r = $urandom_range(0, 99);
      if (r < 50 || (r < 85 && live_runs.size() == 0)) begin
        r = $urandom_range(0, 99);
        if (r < 80) count = $urandom_range(1, 8);
        else if (r < 95) count = $urandom_range(9, 40);
        else count = $urandom_range(41, 255);
        send_word(CMD_ALLOC, count, $urandom_range(0, 255));
      end else if (r < 85) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        run = live_runs[idx];
        live_runs.delete(idx);
        send_word(CMD_FREE, run.pages, run.first);
      end else if (r < 90) begin
        send_word(1'($urandom_range(0, 1)), 0, $urandom_range(0, 255));
      end else if (r < 95) begin
        send_word(CMD_FREE, $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        send_word(CMD_ALLOC, $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.owed.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/prba_pkg.sv
hw/rtl/prba_mark_ram.sv
hw/rtl/page_run_bitmap_allocator.sv
bench/tb.sv
